@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// Users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ivdc_pkg.sv @@
// Package for the volume descriptor checker: word types, field offsets,
// status codes and small helper functions. No dependencies.
package ivdc_pkg;

  localparam int SectorBytes = 2048;
  localparam int OffW        = $clog2(SectorBytes);

  localparam logic [15:0] DefMinBlock = 16'd2048;
  localparam logic [7:0]  MinRootLen  = 8'd33;
  localparam logic [7:0]  TypePrimary = 8'h01;
  localparam logic [7:0]  TypeTerm    = 8'hFF;
  localparam logic [7:0]  VersionOne  = 8'h01;

  // Byte offsets inside the descriptor sector.
  localparam logic [OffW-1:0] OffType      = OffW'(0);
  localparam logic [OffW-1:0] OffMagicLast = OffW'(5);
  localparam logic [OffW-1:0] OffVersion   = OffW'(6);
  localparam logic [OffW-1:0] OffBlocksLe  = OffW'(80);
  localparam logic [OffW-1:0] OffBlocksBe  = OffW'(84);
  localparam logic [OffW-1:0] OffEscFirst  = OffW'(88);
  localparam logic [OffW-1:0] OffEscCheck  = OffW'(90);
  localparam logic [OffW-1:0] OffEscLast   = OffW'(119);
  localparam logic [OffW-1:0] OffSetCount  = OffW'(120);
  localparam logic [OffW-1:0] OffSequence  = OffW'(124);
  localparam logic [OffW-1:0] OffBlockSize = OffW'(128);
  localparam logic [OffW-1:0] OffPtBytes   = OffW'(132);
  localparam logic [OffW-1:0] OffPtL       = OffW'(140);
  localparam logic [OffW-1:0] OffPtM       = OffW'(148);
  localparam logic [OffW-1:0] OffRootLen   = OffW'(156);
  localparam logic [OffW-1:0] OffRootExt   = OffW'(158);
  localparam logic [OffW-1:0] OffRootSize  = OffW'(166);
  localparam logic [OffW-1:0] OffLast      = OffW'(SectorBytes - 1);

  // Characters of the escape sequence scan.
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChE     = 8'h45;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TERMINATOR = 3'd1,
    ST_OTHER_TYPE = 3'd2,
    ST_BAD_MAGIC  = 3'd3,
    ST_BAD_VER    = 3'd4,
    ST_BAD_BSIZE  = 3'd5,
    ST_ZERO_VOL   = 3'd6,
    ST_SHORT_ROOT = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] lblk_size;
    logic [31:0] vol_blocks;
    logic [47:0] volume_bytes;
    logic [31:0] path_table_bytes;
    logic [31:0] path_table_l_loc;
    logic [31:0] path_table_m_loc;
    logic [31:0] root_lba;
    logic [31:0] root_bytes;
    logic [15:0] volume_set_count;
    logic [15:0] volume_sequence;
    logic        joliet_found;
  } out_word_t;

  // Per-sector capture state.
  typedef struct packed {
    logic [7:0]  desc_type;
    logic        magic_ok;
    logic [7:0]  version;
    logic [31:0] vol_blocks;
    logic        vol_be_zero;
    logic [15:0] esc_hist;
    logic        joliet;
    logic [15:0] set_count;
    logic [15:0] sequence_no;
    logic [15:0] lblk_size;
    logic [31:0] pt_bytes;
    logic [31:0] pt_l;
    logic [31:0] pt_m;
    logic [7:0]  root_len;
    logic [31:0] root_ext;
    logic [31:0] root_bytes;
  } cap_t;

  // Flow status of the summary stage.
  typedef struct packed {
    logic fin_valid;
    logic fin_free;
  } judge_stat_t;

  function automatic cap_t cap_clear();
    cap_t c;
    c             = '0;
    c.magic_ok    = 1'b1;
    c.vol_be_zero = 1'b1;
    return c;
  endfunction

  // Expected magic character for offsets one to five.
  function automatic logic [7:0] magic_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd1:       ch = 8'h43;
      3'd2:       ch = 8'h44;
      3'd3, 3'd4: ch = 8'h30;
      3'd5:       ch = 8'h31;
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [31:0] put_lane32(logic [31:0] w, logic [1:0] lane,
                                             logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] put_lane16(logic [15:0] w, logic lane,
                                             logic [7:0] b);
    logic [15:0] r;
    r = w;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

endpackage

@@ rtl/iso9660_volume_descriptor_check_top.sv @@
// Volume descriptor checker, top level. Takes one sector byte per cycle while input ready is high.
// The last sector byte loads the summary stage, which then feeds the output register.
// Throughput: one byte per cycle; input ready drops only while one summary
// waits in the output register and a second one is already held behind it.
// Reset (asynchronous, active low) clears the offset counter, the captured
// fields and the valid flags of both summary stages, and sets the minimum block size to 2048.
`include "assert_macros.svh"

module iso9660_volume_descriptor_check_top import ivdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        take;
  logic        last;
  cap_t        cap;
  judge_stat_t stat;
  logic [15:0] min_block_q;
  logic        out_bsize_pow2;

  assign in_ready_o  = stat.fin_free;
  assign take        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register: minimum block size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_block_q <= DefMinBlock;
    end else if (cfg_valid_i) begin
      min_block_q <= cfg_data_i;
    end
  end

  ivdc_capture u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_word_i (in_word_i),
    .last_o    (last),
    .cap_o     (cap)
  );

  ivdc_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && last),
    .cap_i       (cap),
    .min_block_i (min_block_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .stat_o      (stat)
  );

  // Flags whether the output block size is a nonzero power of two.
  assign out_bsize_pow2 = (out_word_o.lblk_size != 16'd0) &&
                          ((out_word_o.lblk_size & (out_word_o.lblk_size - 16'd1)) == 16'd0);

  // A held summary moves to an empty output register in the next cycle.
  `ASSERT_NEXT(a_fin_moves, stat.fin_valid && !out_valid_o, out_valid_o, "summary stuck")
  // Input stalls only behind a held summary.
  `ASSERT_IMPL(a_stall_cause, !in_ready_o, stat.fin_valid, "stall without summary")
  // An accepted descriptor has a power-of-two block size.
  `ASSERT_IMPL(a_ok_bsize, out_valid_o && out_word_o.status == ST_OK, out_bsize_pow2, "bad size")

endmodule

@@ rtl/ivdc_capture.sv @@
// Byte offset counter and field capture for one descriptor sector.
// Depends on ivdc_pkg.
module ivdc_capture import ivdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_word_t in_word_i,
  output logic     last_o,
  output cap_t     cap_o
);

  logic [OffW-1:0] cnt_q, cnt_d;
  logic [OffW-1:0] off;
  cap_t            cap_q, base, nxt;
  logic [7:0]      b;

  assign b   = in_word_i.data_byte;
  assign off = in_word_i.first_byte ? OffType : cnt_q;

  // Apply the incoming byte at its offset; a sector start clears first.
  always_comb begin
    base = (off == OffType) ? cap_clear() : cap_q;
    nxt  = base;
    if (off == OffType) begin
      nxt.desc_type = b;
    end else if (off <= OffMagicLast) begin
      if (b != magic_char(off[2:0])) nxt.magic_ok = 1'b0;
    end else if (off == OffVersion) begin
      nxt.version = b;
    end else if (off >= OffBlocksLe && off < OffBlocksBe) begin
      nxt.vol_blocks = put_lane32(base.vol_blocks, 2'(off - OffBlocksLe), b);
    end else if (off >= OffBlocksBe && off < OffEscFirst) begin
      if (b != 8'h00) nxt.vol_be_zero = 1'b0;
    end else if (off >= OffEscFirst && off <= OffEscLast) begin
      if (off >= OffEscCheck && base.esc_hist[15:8] == ChPct &&
          base.esc_hist[7:0] == ChSlash && (b == ChAt || b == ChC || b == ChE)) begin
        nxt.joliet = 1'b1;
      end
      nxt.esc_hist = {base.esc_hist[7:0], b};
    end else if (off >= OffSetCount && off < OffSetCount + OffW'(2)) begin
      nxt.set_count = put_lane16(base.set_count, off[0], b);
    end else if (off >= OffSequence && off < OffSequence + OffW'(2)) begin
      nxt.sequence_no = put_lane16(base.sequence_no, off[0], b);
    end else if (off >= OffBlockSize && off < OffBlockSize + OffW'(2)) begin
      nxt.lblk_size = put_lane16(base.lblk_size, off[0], b);
    end else if (off >= OffPtBytes && off < OffPtBytes + OffW'(4)) begin
      nxt.pt_bytes = put_lane32(base.pt_bytes, 2'(off - OffPtBytes), b);
    end else if (off >= OffPtL && off < OffPtL + OffW'(4)) begin
      nxt.pt_l = put_lane32(base.pt_l, 2'(off - OffPtL), b);
    end else if (off >= OffPtM && off < OffPtM + OffW'(4)) begin
      // Big-endian copy: first byte lands in the top lane.
      nxt.pt_m = put_lane32(base.pt_m, ~2'(off - OffPtM), b);
    end else if (off == OffRootLen) begin
      nxt.root_len = b;
    end else if (off >= OffRootExt && off < OffRootExt + OffW'(4)) begin
      nxt.root_ext = put_lane32(base.root_ext, 2'(off - OffRootExt), b);
    end else if (off >= OffRootSize && off < OffRootSize + OffW'(4)) begin
      nxt.root_bytes = put_lane32(base.root_bytes, 2'(off - OffRootSize), b);
    end
  end

  // The counter wraps after a full sector.
  assign cnt_d  = off + OffW'(1);
  assign last_o = (off == OffLast);
  assign cap_o  = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= cap_clear();
    end else if (take_i) begin
      cnt_q <= cnt_d;
      cap_q <= nxt;
    end
  end

endmodule

@@ rtl/ivdc_judge.sv @@
// Summary stage: holds the finished sector fields, checks them, forms the
// volume byte count and keeps the output word. Depends on ivdc_pkg.
module ivdc_judge import ivdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  cap_t        cap_i,
  input  logic [15:0] min_block_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_word_t   out_word_o,
  output judge_stat_t stat_o
);

  logic      fin_valid_q, fin_valid_d;
  cap_t      fin_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      out_load;
  status_e   status;
  logic      bsize_bad;

  assign out_load        = fin_valid_q && (!out_valid_q || out_ready_i);
  assign stat_o.fin_valid = fin_valid_q;
  assign stat_o.fin_free  = !fin_valid_q || out_load;

  // Block size must be nonzero, a power of two and at least the minimum.
  assign bsize_bad = (fin_q.lblk_size == 16'd0) || (fin_q.lblk_size < min_block_i) ||
                     ((fin_q.lblk_size & (fin_q.lblk_size - 16'd1)) != 16'd0);

  // First failing check decides the status.
  always_comb begin
    if (!fin_q.magic_ok)                                   status = ST_BAD_MAGIC;
    else if (fin_q.desc_type == TypeTerm)                  status = ST_TERMINATOR;
    else if (fin_q.desc_type != TypePrimary)               status = ST_OTHER_TYPE;
    else if (fin_q.version != VersionOne)                  status = ST_BAD_VER;
    else if (bsize_bad)                                    status = ST_BAD_BSIZE;
    else if (fin_q.vol_blocks == 32'd0 && fin_q.vol_be_zero) status = ST_ZERO_VOL;
    else if (fin_q.root_len < MinRootLen)                  status = ST_SHORT_ROOT;
    else                                                   status = ST_OK;
  end

  // Output word built from the held fields.
  always_comb begin
    out_d.status           = status;
    out_d.lblk_size        = fin_q.lblk_size;
    out_d.vol_blocks       = fin_q.vol_blocks;
    out_d.volume_bytes     = 48'(fin_q.vol_blocks) * 48'(fin_q.lblk_size);
    out_d.path_table_bytes = fin_q.pt_bytes;
    out_d.path_table_l_loc = fin_q.pt_l;
    out_d.path_table_m_loc = fin_q.pt_m;
    out_d.root_lba         = fin_q.root_ext;
    out_d.root_bytes       = fin_q.root_bytes;
    out_d.volume_set_count = fin_q.set_count;
    out_d.volume_sequence  = fin_q.sequence_no;
    out_d.joliet_found     = fin_q.joliet;
  end

  // Valid flags of the two stages.
  always_comb begin
    fin_valid_d = fin_valid_q;
    if (load_i)        fin_valid_d = 1'b1;
    else if (out_load) fin_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_i)   fin_q <= cap_i;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
